FILE: hdl/hpoc_pkg.sv
// Shared types and constants for the hex point-to-offset-cell converter.
package hpoc_pkg;

    localparam int COORD_WIDTH    = 24;
    localparam int INDEX_WIDTH    = 16;
    localparam int TILE_INV_WIDTH = 24;
    localparam int SQRT3_Q20      = 1816187;
    localparam int SQRT3_WIDTH    = 21;
    localparam int CFG_ADDR_WIDTH = 4;
    localparam int CFG_DATA_WIDTH = 32;

    typedef enum logic [1:0] {
        REG_ORIGIN_X = 2'd0,
        REG_ORIGIN_Y = 2'd1,
        REG_INV_TILE = 2'd2
    } t_reg_index;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
    } t_in_item;

    typedef struct packed {
        logic signed [INDEX_WIDTH-1:0] col;
        logic signed [INDEX_WIDTH-1:0] row;
        logic                          not_configured;
    } t_out_item;

endpackage

FILE: hdl/hex_pixel_to_offset_coord_core.sv
// Top level: world point to flat-top odd-q hex cell, eight-stage pipeline with APB registers.
//
//   channel  | direction | handshake                     | payload
//   ---------+-----------+-------------------------------+---------------------------
//   item in  | input     | start high, busy low          | i_item   (pos_x, pos_y)
//   result   | output    | o_strobe, one cycle per item  | o_result (col, row, flag)
//   config   | APB       | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// One item may enter every cycle; busy stays low, so start is always taken.
// Each result appears on o_strobe for one cycle, after the stage chain: offset,
// scale multiply, sqrt(3) multiply, cube sums, two divide-by-three stages, rounding errors,
// axis fix-up and output register. Reset (synchronous, active low) clears the valid line and
// the registers; items in flight are dropped. The receiver cannot stall, so the pipeline
// never holds.
module hex_pixel_to_offset_coord_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  hpoc_pkg::t_in_item                  i_item,
    output logic                                o_strobe,
    output hpoc_pkg::t_out_item                 o_result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hpoc_pkg::CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [hpoc_pkg::CFG_DATA_WIDTH-1:0] pwdata,
    output logic [hpoc_pkg::CFG_DATA_WIDTH-1:0] prdata,
    output logic                                pready
);
    import hpoc_pkg::*;

    // datapath widths, most derived from the field widths
    localparam int CW   = COORD_WIDTH;
    localparam int IW   = INDEX_WIDTH;
    localparam int TW   = TILE_INV_WIDTH;
    localparam int DW   = CW + 1;          // offset from origin
    localparam int PW   = DW + TW;         // offset times reciprocal radius
    localparam int UW   = PW - 16;         // scaled offset, Q.16
    localparam int KW   = SQRT3_WIDTH + 1; // signed sqrt(3) constant
    localparam int KVW  = UW + KW;
    localparam int A3W  = UW + 23;         // three times a cube coordinate, Q.36
    localparam int TW1  = A3W + 1;         // biased for round-half-up
    localparam int WW   = TW1 - 36;        // integer part of the biased value
    localparam int NB   = WW + 1;          // offset-binary dividend
    localparam int RW   = WW + 2;          // rounded axis after rebuild
    localparam int SW   = ((RW + 1 > IW) ? RW + 1 : IW) + 1;
    localparam int EDW  = 39;              // signed rounding error
    localparam int EW   = EDW - 1;
    localparam int NST  = 8;               // pipeline depth

    localparam logic signed [KW-1:0]  K_SQRT3 = KW'(SQRT3_Q20);
    localparam logic [TW1-1:0]        T_OFF   = TW1'(64'd3 << 35);
    localparam logic [NB-1:0]         N_OFF   = NB'(64'd3 << (WW - 1));
    localparam logic [NB-1:0]         Q_OFF   = NB'(64'd1 << (WW - 1));
    localparam logic signed [EDW-1:0] E_MID   = EDW'(64'd3 << 35);
    localparam logic signed [SW-1:0]  SAT_HI  = SW'((64'sd1 <<< (IW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0]  SAT_LO  = -SAT_HI - SW'(1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [CW-1:0] r_origin_x;
    logic signed [CW-1:0] r_origin_y;
    logic [TW-1:0]        r_inv_tile;
    logic                 cfg_wr;
    t_reg_index           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_index'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_inv_tile <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ORIGIN_X: r_origin_x <= $signed(pwdata[CW-1:0]);
                REG_ORIGIN_Y: r_origin_y <= $signed(pwdata[CW-1:0]);
                REG_INV_TILE: r_inv_tile <= pwdata[TW-1:0];
                default: ; // drop writes above the register list
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ORIGIN_X: prdata = CFG_DATA_WIDTH'(r_origin_x);
            REG_ORIGIN_Y: prdata = CFG_DATA_WIDTH'(r_origin_y);
            REG_INV_TILE: prdata = CFG_DATA_WIDTH'(r_inv_tile);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // valid line and unconfigured flag, one bit per stage
    // ------------------------------------------------------------------
    logic           accept;
    logic [NST-1:0] r_vld;
    logic [NST-1:0] r_nc;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NST-2:0], accept};
        end
    end

    // sample the flag with the item so it travels alongside it
    always_ff @(posedge i_clk) begin
        r_nc <= {r_nc[NST-2:0], (r_inv_tile == '0)};
    end

    // ------------------------------------------------------------------
    // stage 1: offset from grid origin
    // ------------------------------------------------------------------
    logic signed [DW-1:0] r_s1_dx;
    logic signed [DW-1:0] r_s1_dy;

    always_ff @(posedge i_clk) begin
        r_s1_dx <= DW'($signed(i_item.pos_x)) - DW'(r_origin_x);
        r_s1_dy <= DW'($signed(i_item.pos_y)) - DW'(r_origin_y);
    end

    // ------------------------------------------------------------------
    // stage 2: scale by reciprocal radius, floor to Q.16
    // ------------------------------------------------------------------
    logic signed [PW-1:0] prod_x;
    logic signed [PW-1:0] prod_y;
    logic signed [UW-1:0] r_s2_u;
    logic signed [UW-1:0] r_s2_v;

    assign prod_x = r_s1_dx * $signed({1'b0, r_inv_tile});
    assign prod_y = r_s1_dy * $signed({1'b0, r_inv_tile});

    always_ff @(posedge i_clk) begin
        r_s2_u <= prod_x[PW-1:16];
        r_s2_v <= prod_y[PW-1:16];
    end

    // ------------------------------------------------------------------
    // stage 3: sqrt(3) times v
    // ------------------------------------------------------------------
    logic signed [KVW-1:0] kv;
    logic signed [KVW-1:0] r_s3_kv;
    logic signed [UW-1:0]  r_s3_u;

    assign kv = r_s2_v * K_SQRT3;

    always_ff @(posedge i_clk) begin
        r_s3_kv <= kv;
        r_s3_u  <= r_s2_u;
    end

    // ------------------------------------------------------------------
    // stage 4: cube coordinates times three, biased by one half and split
    // into integer part (offset binary for the divider) and fraction
    // ------------------------------------------------------------------
    logic signed [A3W-1:0] a3 [3];
    logic [TW1-1:0]        tb [3];
    logic [NB-1:0]         r_s4_n   [3];
    logic [35:0]           r_s4_tlo [3];

    assign a3[0] = A3W'(r_s3_u) <<< 21;
    assign a3[2] = A3W'(r_s3_kv) - (A3W'(r_s3_u) <<< 20);
    assign a3[1] = -a3[0] - a3[2];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            tb[l] = TW1'(a3[l]) + T_OFF;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_s4_n[l]   <= {tb[l][TW1-1], tb[l][TW1-1:36]} + N_OFF;
            r_s4_tlo[l] <= tb[l][35:0];
        end
    end

    // ------------------------------------------------------------------
    // stages 5 and 6: floor divide by three, one divider per axis
    // ------------------------------------------------------------------
    logic [NB-1:0] div_q   [3];
    logic [1:0]    div_rem [3];
    logic [35:0]   r_s5_tlo [3];
    logic [35:0]   r_s6_tlo [3];

    for (genvar g = 0; g < 3; g++) begin : g_axis
        hpoc_div3 #(
            .NB (NB)
        ) u_div3 (
            .i_clk (i_clk),
            .i_n   (r_s4_n[g]),
            .o_q   (div_q[g]),
            .o_rem (div_rem[g])
        );
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_s5_tlo[l] <= r_s4_tlo[l];
            r_s6_tlo[l] <= r_s5_tlo[l];
        end
    end

    // ------------------------------------------------------------------
    // stage 7: rounded axis and its rounding error, from remainder and fraction
    // ------------------------------------------------------------------
    logic [NB-1:0]          q_unb [3];
    logic signed [EDW-1:0]  ediff [3];
    logic signed [WW-1:0]   r_s7_n [3];
    logic [EW-1:0]          r_s7_e [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            q_unb[l] = div_q[l] - Q_OFF;
            ediff[l] = E_MID - $signed({1'b0, div_rem[l], 36'd0})
                             - $signed({3'b000, r_s6_tlo[l]});
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_s7_n[l] <= $signed(q_unb[l][WW-1:0]);
            r_s7_e[l] <= ediff[l][EDW-1] ? EW'(-ediff[l]) : EW'(ediff[l]);
        end
    end

    // ------------------------------------------------------------------
    // stage 8: rebuild the worst axis, map to odd-q, saturate
    // ------------------------------------------------------------------
    logic signed [RW-1:0] rx;
    logic signed [RW-1:0] rz;
    logic signed [RW:0]   half_x;
    logic signed [RW:0]   row_w;
    logic [IW-1:0]        col_sat;
    logic [IW-1:0]        row_sat;

    function automatic logic [IW-1:0] sat_index(input logic signed [SW-1:0] v);
        logic [IW-1:0] res;
        priority if (v > SAT_HI) begin
            res = SAT_HI[IW-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[IW-1:0];
        end else begin
            res = v[IW-1:0];
        end
        return res;
    endfunction

    always_comb begin
        rx = RW'(r_s7_n[0]);
        rz = RW'(r_s7_n[2]);
        priority if (r_s7_e[0] > r_s7_e[1] && r_s7_e[0] > r_s7_e[2]) begin
            rx = -RW'(r_s7_n[1]) - RW'(r_s7_n[2]);
        end else if (r_s7_e[1] > r_s7_e[2]) begin
            // y is rebuilt: x and z stand, and y is not needed further on
        end else begin
            rz = -RW'(r_s7_n[0]) - RW'(r_s7_n[1]);
        end
        // drop the odd bit first, so the halving is exact
        half_x  = (RW+1)'(rx) - $signed({{RW{1'b0}}, rx[0]});
        row_w   = (RW+1)'(rz) + (half_x >>> 1);
        col_sat = sat_index(SW'(rx));
        row_sat = sat_index(SW'(row_w));
    end

    always_ff @(posedge i_clk) begin
        if (r_nc[NST-2]) begin
            o_result.col <= '1;
            o_result.row <= '1;
        end else begin
            o_result.col <= $signed(col_sat);
            o_result.row <= $signed(row_sat);
        end
        o_result.not_configured <= r_nc[NST-2];
    end

    assign o_strobe = r_vld[NST-1];

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_strobe_follows_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, NST))
        else $error("result strobe without an item accepted %0d cycles earlier", NST);

    a_flag_matches_config : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.not_configured == $past(r_inv_tile == '0, NST)))
        else $error("unconfigured flag does not match reciprocal radius at accept");

    a_flag_gives_minus_one : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.not_configured) |->
            (o_result.col == '1 && o_result.row == '1))
        else $error("unconfigured result is not -1,-1");

endmodule

FILE: hdl/hpoc_div3.sv
// Two-stage unsigned divide by three with remainder, reciprocal multiply and one correction.
module hpoc_div3 #(
    parameter int NB = 10
) (
    input  logic          i_clk,
    input  logic [NB-1:0] i_n,
    output logic [NB-1:0] o_q,
    output logic [1:0]    o_rem
);
    localparam logic [NB-1:0] RECIP = NB'(((64'd1 << NB) - 64'd1) / 64'd3);

    logic [2*NB-1:0] prod;
    logic [NB-1:0]   r_n;
    logic [NB-1:0]   r_q0;
    logic [NB-1:0]   diff;
    logic [2:0]      rem3;
    logic [NB-1:0]   n_q;
    logic [1:0]      n_rem;

    assign prod = i_n * RECIP;

    // estimate is exact or one short
    assign diff = r_n - (r_q0 + (r_q0 << 1));
    assign rem3 = diff[2:0];

    always_comb begin
        if (rem3 >= 3'd3) begin
            n_q   = r_q0 + NB'(1);
            n_rem = 2'(rem3 - 3'd3);
        end else begin
            n_q   = r_q0;
            n_rem = rem3[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= i_n;
        r_q0  <= prod[2*NB-1:NB];
        o_q   <= n_q;
        o_rem <= n_rem;
    end

endmodule
